/* hdl/seqlst_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sequential list table.
// Used by the controller, the datapath and the top level; depends on nothing.
package seqlst_pkg;

   // Fixed widths of the request and response fields.
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int LIMIT_W = 7;

   // Number of entries in the list memory; the field widths above are sized for it.
   localparam int DEPTH = 64;

   // Capacity limit after reset.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_RANGE    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                    command;
      logic [INDEX_W-1:0]         index;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  position;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DEL_RD,
      S_DEL_WR,
      S_FINISH
   } state_type;

   // Pointer operations.
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_COUNT_M1,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   // Memory write operations.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_PUSH,
      WR_UP,
      WR_DOWN,
      WR_PUT
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // Source of the reported position.
   typedef enum logic [1:0] {
      POS_ZERO,
      POS_COUNT,
      POS_IDX,
      POS_PTR
   } pos_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch_req;
      ptr_op_type   ptr_op;
      logic         mem_rd;
      wr_op_type    wr_op;
      cnt_op_type   cnt_op;
      logic         res_set;
      status_type   res_status;
      pos_sel_type  res_pos;
      logic         load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type  command;
      logic     idx_ge_count;
      logic     full;
      logic     count_zero;
      logic     match;
      logic     ptr_eq_idx;
      logic     ptr_last;
      logic     rsp_free;
   } ctrl_stat_type;

endpackage

/* hdl/seqlst_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the sequential list table.
// Depends on seqlst_pkg; drives the datapath through command and status structs.
module seqlst_ctrl
   import seqlst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.command) inside
               CMD_PUSH: state_in = S_FINISH;
               CMD_INSERT: begin
                  if (stat.idx_ge_count || stat.full) state_in = S_FINISH;
                  else state_in = S_INS_RD;
               end
               CMD_DELETE, CMD_FIND: begin
                  if (stat.count_zero) state_in = S_FINISH;
                  else state_in = S_SRCH_RD;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_INS_RD: state_in = S_INS_WR;
         S_INS_WR: begin
            if (stat.ptr_eq_idx) state_in = S_INS_PUT;
            else state_in = S_INS_RD;
         end
         S_INS_PUT: state_in = S_FINISH;
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (stat.match) begin
               if (stat.command == CMD_FIND || stat.ptr_last) state_in = S_FINISH;
               else state_in = S_DEL_RD;
            end else if (stat.ptr_last) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_DEL_RD: state_in = S_DEL_WR;
         S_DEL_WR: begin
            if (stat.ptr_last) state_in = S_FINISH;
            else state_in = S_DEL_RD;
         end
         S_FINISH: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready      = 1'b0;
      cmd.latch_req  = 1'b0;
      cmd.ptr_op     = PTR_HOLD;
      cmd.mem_rd     = 1'b0;
      cmd.wr_op      = WR_NONE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.res_set    = 1'b0;
      cmd.res_status = STAT_OK;
      cmd.res_pos    = POS_ZERO;
      cmd.load_rsp   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
         end
         S_DECODE: begin
            unique case (stat.command) inside
               CMD_PUSH: begin
                  cmd.res_set = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = STAT_FULL;
                  end else begin
                     cmd.wr_op   = WR_PUSH;
                     cmd.cnt_op  = CNT_INC;
                     cmd.res_pos = POS_COUNT;
                  end
               end
               CMD_INSERT: begin
                  // Range is checked before full.
                  if (stat.idx_ge_count) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_RANGE;
                  end else if (stat.full) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_FULL;
                  end else begin
                     cmd.ptr_op = PTR_COUNT_M1;
                  end
               end
               CMD_DELETE, CMD_FIND: begin
                  if (stat.count_zero) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STAT_NOTFOUND;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                  end
               end
               default: cmd.ptr_op = PTR_HOLD;
            endcase
         end
         S_INS_RD: cmd.mem_rd = 1'b1;
         S_INS_WR: begin
            cmd.wr_op = WR_UP;
            if (!stat.ptr_eq_idx) cmd.ptr_op = PTR_DEC;
         end
         S_INS_PUT: begin
            cmd.wr_op   = WR_PUT;
            cmd.cnt_op  = CNT_INC;
            cmd.res_set = 1'b1;
            cmd.res_pos = POS_IDX;
         end
         S_SRCH_RD: cmd.mem_rd = 1'b1;
         S_SRCH_CMP: begin
            if (stat.match) begin
               cmd.res_set = 1'b1;
               cmd.res_pos = POS_PTR;
               if (stat.command == CMD_DELETE) begin
                  // Nothing above the match means no shift is needed.
                  if (stat.ptr_last) cmd.cnt_op = CNT_DEC;
                  else cmd.ptr_op = PTR_INC;
               end
            end else if (stat.ptr_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STAT_NOTFOUND;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_DEL_RD: cmd.mem_rd = 1'b1;
         S_DEL_WR: begin
            cmd.wr_op = WR_DOWN;
            if (stat.ptr_last) cmd.cnt_op = CNT_DEC;
            else cmd.ptr_op = PTR_INC;
         end
         S_FINISH: cmd.load_rsp = stat.rsp_free;
         default: req_ready = 1'b0;
      endcase
   end

`ifndef NO_ASSERTIONS
   // An accepted request is always decoded in the next cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

   // A finished request leaves once the response slot is free.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && stat.rsp_free) |=> (state_ff == S_IDLE))
      else $error("finish did not return to idle");

   // A request is latched only at an accepting edge.
   a_latch_handshake: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |-> (req_valid && req_ready))
      else $error("request latched without a handshake");
`endif

endmodule

/* hdl/seqlst_dp.sv */
`timescale 1ns / 1ps
// Datapath of the sequential list table: entry memory, count, pointer,
// capacity register and response register. Depends on seqlst_pkg.
module seqlst_dp
   import seqlst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_payload,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   input  ctrl_cmd_type        cmd,
   output ctrl_stat_type       stat
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [VALUE_W-1:0]  mem [DEPTH];
   logic [VALUE_W-1:0]  rdata_ff;
   req_type             req_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]    ptr_in;
   logic [LIMIT_W-1:0]  limit_ff;
   status_type          res_status_ff;
   logic [INDEX_W-1:0]  res_pos_ff;
   logic [INDEX_W-1:0]  res_pos_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [CNT_W-1:0]    ptr_p1;
   logic [CNT_W-1:0]    ptr_m1;
   logic [CNT_W-1:0]    idx_c;
   logic [EW-1:0]       count_ext;
   logic [EW-1:0]       pos_ext;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VALUE_W-1:0]  wr_data;

   assign ptr_p1    = ptr_ff + 1'b1;
   assign ptr_m1    = ptr_ff - 1'b1;
   assign idx_c     = CNT_W'(req_ff.index);
   assign count_ext = EW'(count_ff);

   // Status toward the controller.
   always_comb begin
      stat.command      = req_ff.command;
      stat.idx_ge_count = EW'(req_ff.index) >= count_ext;
      stat.full         = (count_ext >= EW'(limit_ff)) || (count_ff >= DEPTH_C);
      stat.count_zero   = (count_ff == '0);
      stat.match        = (rdata_ff == req_ff.value);
      stat.ptr_eq_idx   = (ptr_ff == idx_c);
      stat.ptr_last     = (ptr_p1 >= count_ff);
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Request latch and capacity register.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Pointer and count.
   always_comb begin
      case (cmd.ptr_op)
         PTR_ZERO:     ptr_in = '0;
         PTR_COUNT_M1: ptr_in = count_ff - 1'b1;
         PTR_INC:      ptr_in = ptr_p1;
         PTR_DEC:      ptr_in = ptr_m1;
         default:      ptr_in = ptr_ff;
      endcase
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + 1'b1;
         CNT_DEC: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Memory write port selection.
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = rdata_ff;
      case (cmd.wr_op)
         WR_PUSH: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = req_ff.value;
         end
         WR_UP:   wr_addr = ptr_p1[AW-1:0];
         WR_DOWN: wr_addr = ptr_m1[AW-1:0];
         WR_PUT: begin
            wr_addr = idx_c[AW-1:0];
            wr_data = req_ff.value;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rdata_ff <= mem[ptr_ff[AW-1:0]];
   end

   // Result held until the response register is loaded.
   always_comb begin
      case (cmd.res_pos)
         POS_COUNT: pos_ext = EW'(count_ff);
         POS_IDX:   pos_ext = EW'(req_ff.index);
         POS_PTR:   pos_ext = EW'(ptr_ff);
         default:   pos_ext = '0;
      endcase
      res_pos_in = pos_ext[INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_pos_ff    <= res_pos_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status   <= res_status_ff;
         rsp_ff.position <= res_pos_ff;
         rsp_ff.count    <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // The count never passes the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("count above depth");

   // The count only grows while the memory still has room.
   a_inc_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == CNT_INC) |-> (count_ff < DEPTH_C))
      else $error("count increment at full memory");

   // A response is loaded only into a free slot.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");
`endif

endmodule

/* hdl/sequential_list_table.sv */
`timescale 1ns / 1ps
// Top level of the sequential list table: ordered list with push, insert,
// delete and find. Depends on seqlst_pkg, seqlst_ctrl and seqlst_dp.
//
//   Channel  Ports                                 Direction
//   request  req_valid, req_ready, req_payload     in
//   response rsp_valid, rsp_ready, rsp_payload     out
//   control  csr_wr_en, csr_wr_data                in (capacity limit)
//
// One request is worked at a time; the entry memory sets the pace.
// Insert shifts the entries from the end down to the index up, one read and one write each,
// then puts the value. Find and delete scan from the front; delete shifts the rest down.
// Reset clears the count and sets the capacity limit to 64; entries are not cleared.
// A waiting response holds only the finish step; the next request is taken after it.
module sequential_list_table
   import seqlst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_payload,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequencer.
   seqlst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   seqlst_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

/* tb/list_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the sequential list table: watches the request, response and
// control ports, predicts each response and compares it. Depends on seqlst_pkg.
module list_table_checker
   import seqlst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_payload,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   output int                  fail_count,
   output int                  pending_results
);

   // Shadow copy of the list contents, its length and the capacity limit.
   logic signed [VALUE_W-1:0] list_vals [DEPTH];
   int                        list_len;
   logic [LIMIT_W-1:0]        cap_limit;

   rsp_type predicted_rsp_q [$];
   rsp_type want_rsp;

   // Apply one command to the shadow list and return the response it earns.
   function automatic rsp_type predict_list_op(input req_type rq);
      rsp_type r;
      int      lim;
      int      hit;
      lim = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
      r.status = STAT_OK;
      r.position = '0;
      hit = -1;
      case (rq.command)
         CMD_PUSH: begin
            if (list_len >= lim) begin
               r.status = STAT_FULL;
            end else begin
               r.position = list_len[INDEX_W-1:0];
               list_vals[list_len] = rq.value;
               list_len++;
            end
         end
         CMD_INSERT: begin
            // The range check wins over the full check.
            if (rq.index >= list_len) begin
               r.status = STAT_RANGE;
            end else if (list_len >= lim) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = list_len; i > rq.index; i--)
                  list_vals[i] = list_vals[i-1];
               list_vals[rq.index] = rq.value;
               r.position = rq.index;
               list_len++;
            end
         end
         default: begin
            // Delete and find both look for the first matching entry.
            for (int i = 0; i < list_len; i++)
               if (hit < 0 && list_vals[i] == rq.value)
                  hit = i;
            if (hit < 0) begin
               r.status = STAT_NOTFOUND;
            end else begin
               r.position = hit[INDEX_W-1:0];
               if (rq.command == CMD_DELETE) begin
                  for (int i = hit + 1; i < list_len; i++)
                     list_vals[i-1] = list_vals[i];
                  list_len--;
               end
            end
         end
      endcase
      r.count = list_len[COUNT_W-1:0];
      return r;
   endfunction

   // Track the configuration, predict on each request and check each response.
   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         cap_limit = LIMIT_RESET;
         predicted_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en)
            cap_limit = csr_wr_data;

         // Responses are retired before new requests so a stray response
         // can never consume the expectation of a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("response with no request outstanding: status %0d position %0d count %0d",
                      rsp_payload.status, rsp_payload.position, rsp_payload.count);
               fail_count++;
            end else begin
               want_rsp = predicted_rsp_q.pop_front();
               if (rsp_payload.status !== want_rsp.status) begin
                  $error("status: expected %0d, got %0d", want_rsp.status, rsp_payload.status);
                  fail_count++;
               end
               if (rsp_payload.position !== want_rsp.position) begin
                  $error("position: expected %0d, got %0d",
                         want_rsp.position, rsp_payload.position);
                  fail_count++;
               end
               if (rsp_payload.count !== want_rsp.count) begin
                  $error("count: expected %0d, got %0d", want_rsp.count, rsp_payload.count);
                  fail_count++;
               end
            end
         end

         if (req_valid && req_ready)
            predicted_rsp_q.push_back(predict_list_op(req_payload));
      end
      pending_results <= predicted_rsp_q.size();
   end

endmodule

/* tb/sequential_list_table_tb.sv */
`timescale 1ns / 1ps
// Top of the sequential list table testbench: clock, reset, request stimulus,
// response flow control and verdict. Depends on seqlst_pkg, the block and list_table_checker.
module sequential_list_table_tb;
   import seqlst_pkg::*;

   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int STEADY_FIRST = 700;
   localparam int STEADY_LAST  = 1000;

   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_EVEN,
      MIX_DRAIN
   } mix_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   int                 fail_count;
   int                 pending_results;

   int                        sent_total = 0;
   int                        rsp_taken  = 0;
   logic signed [VALUE_W-1:0] value_pool [16];

   always #1 clock = ~clock;

   sequential_list_table uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   list_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   function automatic req_type pack_req(input cmd_type c, input int idx,
                                        input logic signed [VALUE_W-1:0] v);
      req_type rq;
      rq.command = c;
      rq.index = idx[INDEX_W-1:0];
      rq.value = v;
      return rq;
   endfunction

   // Random command weighted toward growing, churning or shrinking the list.
   // Values come mostly from a small pool so deletes and finds often hit.
   function automatic req_type random_request(input mix_type mix);
      req_type rq;
      int      roll;
      int      t_push;
      int      t_ins;
      int      t_del;
      case (mix)
         MIX_FILL:  begin t_push = 45; t_ins = 70; t_del = 85; end
         MIX_EVEN:  begin t_push = 30; t_ins = 50; t_del = 75; end
         default:   begin t_push = 15; t_ins = 25; t_del = 70; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < t_push)
         rq.command = CMD_PUSH;
      else if (roll < t_ins)
         rq.command = CMD_INSERT;
      else if (roll < t_del)
         rq.command = CMD_DELETE;
      else
         rq.command = CMD_FIND;
      if ($urandom_range(0, 99) < 60)
         rq.index = INDEX_W'($urandom_range(0, 7));
      else
         rq.index = INDEX_W'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 85)
         rq.value = value_pool[$urandom_range(0, 15)];
      else
         rq.value = $urandom;
      return rq;
   endfunction

   // Offer one request, after random idle gaps outside the steady window, and hold it until the block takes it.
   task automatic send_request(input req_type item);
      if (sent_total < STEADY_FIRST || sent_total >= STEADY_LAST) begin
         while ($urandom_range(0, 99) < 10) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent_total++;
   endtask

   task automatic run_phase(input int n_items, input mix_type mix);
      for (int i = 0; i < n_items; i++)
         send_request(random_request(mix));
      req_valid <= 1'b0;
   endtask

   // Wait until every predicted response has been seen.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   // The limit is only changed once the block has nothing in flight.
   task automatic write_limit(input logic [LIMIT_W-1:0] lim);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Response side: random back-pressure, a quiet window, and one long hold-off
   // that backs the block up while the sender keeps offering.
   initial begin : response_flow
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            rsp_taken++;
         if (rsp_taken == HOLD_AT && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= (rsp_taken >= STEADY_FIRST && rsp_taken < STEADY_LAST)
                         || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // Main sequence: reset, directed requests, then random phases under
   // several capacity limits.
   initial begin : stimulus
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = 32'sh0000_0000;
      value_pool[3] = -32'sd1;
      value_pool[4] = 32'sd1;
      for (int i = 5; i < 16; i++)
         value_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty list: nothing to find, delete or insert in front of.
      send_request(pack_req(CMD_FIND, 0, 32'sd5));
      send_request(pack_req(CMD_DELETE, 0, 32'sd5));
      send_request(pack_req(CMD_INSERT, 0, 32'sd5));
      // Extreme values at the back.
      send_request(pack_req(CMD_PUSH, 0, 32'sh7FFF_FFFF));
      send_request(pack_req(CMD_PUSH, 0, 32'sh8000_0000));
      send_request(pack_req(CMD_PUSH, 0, 32'sh0000_0000));
      send_request(pack_req(CMD_PUSH, 0, -32'sd1));
      // Insert at the front, at the last slot, and out of range.
      send_request(pack_req(CMD_INSERT, 0, 32'sd11));
      send_request(pack_req(CMD_INSERT, 4, 32'sd22));
      send_request(pack_req(CMD_INSERT, 6, 32'sd33));
      send_request(pack_req(CMD_INSERT, 63, 32'sd44));
      // A duplicate so find and delete must pick the first copy.
      send_request(pack_req(CMD_PUSH, 0, -32'sd1));
      send_request(pack_req(CMD_FIND, 0, -32'sd1));
      send_request(pack_req(CMD_FIND, 0, 32'sh8000_0000));
      send_request(pack_req(CMD_FIND, 0, 32'sd12345));
      send_request(pack_req(CMD_DELETE, 0, -32'sd1));
      send_request(pack_req(CMD_DELETE, 0, 32'sd11));
      send_request(pack_req(CMD_DELETE, 0, -32'sd1));
      send_request(pack_req(CMD_DELETE, 0, 32'sd999));
      send_request(pack_req(CMD_FIND, 0, 32'sh7FFF_FFFF));

      // Reset limit: grow until full.
      run_phase(400, MIX_FILL);
      // Limit lowered under the count: pushes and inserts report full.
      write_limit(7'd5);
      run_phase(150, MIX_EVEN);
      // Zero limit: nothing can be added.
      write_limit(7'd0);
      run_phase(60, MIX_EVEN);
      // Limit above the depth acts as the depth.
      write_limit(7'd127);
      run_phase(400, MIX_FILL);
      write_limit(7'd1);
      run_phase(100, MIX_DRAIN);
      write_limit(7'd64);
      run_phase(300, MIX_EVEN);
      write_limit(LIMIT_W'($urandom_range(1, 64)));
      run_phase(200, MIX_EVEN);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Run limit, several times the slowest legal run.
   initial begin : watchdog
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
